[rtl/core/gf256_share_lsb_embed_core_assert.svh]
// Assertion macros shared by the share embedding core and its multiplier.
// Depends on nothing; each file that asserts includes it by name.
`ifndef GF256_SHARE_LSB_EMBED_CORE_ASSERT_SVH
`define GF256_SHARE_LSB_EMBED_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GSLE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gsle same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define GSLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gsle next-cycle check failed");

`endif

[rtl/core/gsle_pkg.sv]
// Shared types, codes and GF(2^8) helpers for the share embedding core.
// Depends on nothing; used by gsle_mac and gf256_share_lsb_embed_core.
package gsle_pkg;

    localparam int MAX_COEFS_DEF = 8;
    localparam int GF_BITS       = 8;
    localparam int GF_CNT_W      = $clog2(GF_BITS);

    // Low byte of the reduction polynomial 0x163; bit 8 is implied.
    localparam logic [7:0]  GF_POLY_LOW  = 8'h63;
    localparam logic [7:0]  KEEP_HIGH    = 8'hF8;
    localparam logic [15:0] PARITY_TABLE = 16'h6996;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_EMBED = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_EVAL,
        ST_FINISH
    } gsle_state_t;

    // Multiply by x modulo the reduction polynomial.
    function automatic logic [7:0] gf_xtime(input logic [7:0] a);
        logic [7:0] r;
        r = {a[6:0], 1'b0};
        if (a[7])
        begin
            r = r ^ GF_POLY_LOW;
        end
        return r;
    endfunction

    // Parity of a byte, folded to a nibble and looked up.
    function automatic logic byte_parity(input logic [7:0] t);
        logic [3:0] nib;
        nib = t[7:4] ^ t[3:0];
        return PARITY_TABLE[nib];
    endfunction

endpackage

[rtl/core/gsle_mac.sv]
// Bit-serial GF(2^8) multiplier, one bit of the multiplier per cycle, MSB first.
// Depends on gsle_pkg and the assertion macro header.
`include "gf256_share_lsb_embed_core_assert.svh"

module gsle_mac (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [7:0] mul_a,
    input  logic [7:0] mul_x,
    output logic       busy,
    output logic       done,
    output logic [7:0] product
);

    logic                          busy_reg, busy_next;
    logic [gsle_pkg::GF_CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]                    a_reg, a_next;
    logic [7:0]                    x_sh_reg, x_sh_next;
    logic [7:0]                    acc_reg, acc_next;
    logic [7:0]                    acc_step;

    assign acc_step = gsle_pkg::gf_xtime(acc_reg) ^ (x_sh_reg[7] ? a_reg : 8'h00);
    assign done     = busy_reg && (cnt_reg == '0);
    assign busy     = busy_reg;
    assign product  = acc_step;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        x_sh_next = x_sh_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = gsle_pkg::GF_CNT_W'(gsle_pkg::GF_BITS - 1);
            a_next    = mul_a;
            x_sh_next = mul_x;
            acc_next  = 8'h00;
        end
        else if (busy_reg)
        begin
            acc_next  = acc_step;
            x_sh_next = {x_sh_reg[6:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        x_sh_reg <= x_sh_next;
        acc_reg  <= acc_next;
    end

    `GSLE_ASSERT_SAME(a_mac_start_free, clk, rst_n, start, !busy_reg || done)
    `GSLE_ASSERT_NEXT(a_mac_start_busy, clk, rst_n, start, busy_reg && (cnt_reg != '0))
    `GSLE_ASSERT_NEXT(a_mac_keeps_busy, clk, rst_n, busy_reg && (cnt_reg != '0), busy_reg)

endmodule

[rtl/core/gf256_share_lsb_embed_core.sv]
// Top level of the GF(2^8) share embedding core: coefficient store, sequencer
// and output register. Depends on gsle_pkg, gsle_mac and the assertion header.
//
// This core computes one Shamir share t = s0 + s1*x + ... + s(k-1)*x^(k-1)
// over GF(2^8) (reduction polynomial 0x163) in Horner order and hides it in
// the low bits of a 2x2 pixel block. A load word (cmd = 0) writes secret_byte
// into coefficient slot coef_index; slots at or above
// MAX_COEFS are ignored. An embed word (cmd = 1) produces one result word:
// out_w, out_v keep bits 7:3 and carry t[7:5] and t[4:2], out_u keeps bits
// 7:3 and carries the parity of t at bit 2 and t[1:0] below it; out_x and
// share_value return x and t. The register coef_count sets k and is
// saturated to MAX_COEFS; it must be written only while the core is idle.
// Every coefficient slot below k must have been loaded before an embed word.
// An embed word occupies the core for a head state that reads the leading
// coefficient, one pass of the bit-serial multiplier per Horner step (one
// bit of x per cycle), and a finish state that hands the result to the
// output register; with k zero it goes straight to the finish state. The
// output register lets the next word be accepted while a result still waits.
`include "gf256_share_lsb_embed_core_assert.svh"

module gf256_share_lsb_embed_core #(
    parameter int MAX_COEFS = gsle_pkg::MAX_COEFS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_wr_en,
    input  logic [3:0] cfg_wr_data,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic       cmd,
    input  logic [2:0] coef_index,
    input  logic [7:0] secret_byte,
    input  logic [7:0] pixel_x,
    input  logic [7:0] pixel_w,
    input  logic [7:0] pixel_v,
    input  logic [7:0] pixel_u,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_x,
    output logic [7:0] out_w,
    output logic [7:0] out_v,
    output logic [7:0] out_u,
    output logic [7:0] share_value
);

    localparam int IDXW = $clog2(MAX_COEFS);
    // Wide enough for both the 4-bit register and MAX_COEFS itself.
    localparam int CW   = ($clog2(MAX_COEFS + 1) > 4) ? $clog2(MAX_COEFS + 1) : 4;

    gsle_pkg::gsle_state_t state_reg, state_next;

    logic [3:0]      coef_count_reg;
    logic [IDXW-1:0] i_reg, i_next;
    logic [7:0]      t_reg, t_next;
    logic [7:0]      x_reg, w_reg, v_reg, u_reg;
    logic [7:0]      rd_data_reg;
    logic [7:0]      store_mem [MAX_COEFS];

    logic [CW-1:0]   cnt_ext, k_sat, k_m1;
    logic            in_accept;
    logic            store_we;
    logic [IDXW-1:0] wr_addr;

    logic            mac_start;
    logic [7:0]      mac_a;
    logic            mac_busy;
    logic            mac_done;
    logic [7:0]      mac_product;

    logic            out_load;
    logic            out_valid_reg;
    logic [7:0]      out_x_reg, out_w_reg, out_v_reg, out_u_reg, share_reg;

    // New words are taken only between embed operations.
    assign in_stall  = (state_reg != gsle_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    assign cnt_ext = CW'(coef_count_reg);
    assign k_sat   = (cnt_ext > CW'(MAX_COEFS)) ? CW'(MAX_COEFS) : cnt_ext;
    assign k_m1    = k_sat - 1'b1;

    assign store_we = in_accept && (cmd == gsle_pkg::CMD_LOAD)
                      && (32'(coef_index) < MAX_COEFS);
    assign wr_addr  = IDXW'(coef_index);

    // Sequencer. i_reg names the coefficient that the next Horner step adds;
    // the store is read at i_next so the registered read data is ready when
    // the multiplier finishes.
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        t_next     = t_reg;
        mac_start  = 1'b0;
        mac_a      = rd_data_reg;
        out_load   = 1'b0;
        case (state_reg)
            gsle_pkg::ST_IDLE:
            begin
                if (in_accept && (cmd == gsle_pkg::CMD_EMBED))
                begin
                    if (k_sat == '0)
                    begin
                        t_next     = 8'h00;
                        state_next = gsle_pkg::ST_FINISH;
                    end
                    else
                    begin
                        i_next     = k_m1[IDXW-1:0];
                        state_next = gsle_pkg::ST_HEAD;
                    end
                end
            end
            gsle_pkg::ST_HEAD:
            begin
                // The leading coefficient has arrived from the store.
                t_next = rd_data_reg;
                if (i_reg == '0)
                begin
                    state_next = gsle_pkg::ST_FINISH;
                end
                else
                begin
                    i_next     = i_reg - 1'b1;
                    mac_start  = 1'b1;
                    mac_a      = rd_data_reg;
                    state_next = gsle_pkg::ST_EVAL;
                end
            end
            gsle_pkg::ST_EVAL:
            begin
                if (mac_done)
                begin
                    t_next = mac_product ^ rd_data_reg;
                    if (i_reg == '0)
                    begin
                        state_next = gsle_pkg::ST_FINISH;
                    end
                    else
                    begin
                        i_next    = i_reg - 1'b1;
                        mac_start = 1'b1;
                        mac_a     = mac_product ^ rd_data_reg;
                    end
                end
            end
            gsle_pkg::ST_FINISH:
            begin
                // Wait until the output register is free or being emptied.
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = gsle_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gsle_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gsle_pkg::ST_IDLE;
            coef_count_reg <= 4'd2;
            i_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            if (cfg_wr_en)
            begin
                coef_count_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Coefficient store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[wr_addr] <= secret_byte;
        end
        rd_data_reg <= store_mem[i_next];
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
        if (in_accept && (cmd == gsle_pkg::CMD_EMBED))
        begin
            x_reg <= pixel_x;
            w_reg <= pixel_w;
            v_reg <= pixel_v;
            u_reg <= pixel_u;
        end
        if (out_load)
        begin
            out_x_reg <= x_reg;
            out_w_reg <= (w_reg & gsle_pkg::KEEP_HIGH) | {5'b0, t_reg[7:5]};
            out_v_reg <= (v_reg & gsle_pkg::KEEP_HIGH) | {5'b0, t_reg[4:2]};
            out_u_reg <= (u_reg & gsle_pkg::KEEP_HIGH)
                         | {5'b0, gsle_pkg::byte_parity(t_reg), t_reg[1:0]};
            share_reg <= t_reg;
        end
    end

    gsle_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mac_start),
        .mul_a   (mac_a),
        .mul_x   (x_reg),
        .busy    (mac_busy),
        .done    (mac_done),
        .product (mac_product)
    );

    assign out_valid   = out_valid_reg;
    assign out_x       = out_x_reg;
    assign out_w       = out_w_reg;
    assign out_v       = out_v_reg;
    assign out_u       = out_u_reg;
    assign share_value = share_reg;

    `GSLE_ASSERT_SAME(a_eval_has_mac, clk, rst_n, state_reg == gsle_pkg::ST_EVAL, mac_busy)
    `GSLE_ASSERT_SAME(a_load_in_finish, clk, rst_n, out_load, state_reg == gsle_pkg::ST_FINISH)
    `GSLE_ASSERT_NEXT(a_index_steps_down, clk, rst_n, mac_start, i_reg == $past(i_reg) - 1'b1)

endmodule
